FILE: rtl/core/tiltq_pkg.sv
// ----------------------------------------------------------------------------
// Tilt alarm qualifier package
// Shared types, register map, reset values and angle helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tiltq_pkg;

  // Register map, word index on the configuration port
  typedef enum logic [1:0] {
    RegZeroAngle     = 2'd0,
    RegTripAngle     = 2'd1,
    RegStepTolerance = 2'd2,
    RegRunNeeded     = 2'd3
  } cfg_reg_e;

  // Register reset values
  localparam logic signed [8:0] ZeroAngleRst     = 9'sd0;
  localparam logic        [8:0] TripAngleRst     = 9'd6;
  localparam logic        [6:0] StepToleranceRst = 7'd3;
  localparam logic        [7:0] RunNeededRst     = 8'd6;

  // Base of the fold applied to negative angles
  localparam logic [8:0] FoldBase = 9'd180;

  // One result transaction
  typedef struct packed {
    logic       alarm_now;
    logic       alarm_latched;
    logic [7:0] run_length;
  } result_t;

  // Fold a negative angle a to 180 - a; keep a non-negative one
  function automatic logic [8:0] fold_angle(input logic signed [8:0] a);
    logic [9:0] diff;
    diff = {1'b0, FoldBase} - {a[8], a};
    return a[8] ? diff[8:0] : a;
  endfunction

  // Absolute difference of two folded angles
  function automatic logic [8:0] abs_diff(input logic [8:0] a, input logic [8:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tiltq_outbuf.sv
// ----------------------------------------------------------------------------
// Tilt alarm qualifier output buffer
// Output register with a skid stage, so a new transaction can be taken while
// a finished result is still waiting downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module tiltq_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tiltq_pkg::result_t push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output tiltq_pkg::result_t     out_data_o
);

  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  tiltq_pkg::result_t out_q, out_d;
  tiltq_pkg::result_t skid_q, skid_d;
  logic               take;

  assign take = out_valid_q && !out_stall_i;

  // Steer new results to the output register or the skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    priority if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The skid stage only holds data behind a valid output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage valid without output register");

  // The skid stage only fills when the output is stalled
  a_skid_fill_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid stage filled while output was free");

  // A stalled result is never dropped
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/tilt_alarm_qualifier.sv
// ----------------------------------------------------------------------------
// Tilt alarm qualifier
// Folds tilt samples, tracks runs of tilted samples and raises a sticky alarm.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+------------------------------
//  in       | in        | in_valid_i / in_stall_o | mode_i, angle_i
//  out      | out       | out_valid_o/ out_stall_i| alarm_now_o, alarm_latched_o,
//           |           |                         | run_length_o
//  config   | in        | APB (pready always high)| zero, trip, tolerance, run
//
//  One transaction per cycle while in_stall_o is low; its result is registered
//  in the output buffer. The qualifier state updates in the accepting cycle, so
//  back-to-back samples see each other with no bubble.
//  A two-entry output buffer (register plus skid) holds one extra result while
//  the output is stalled; in_stall_o is high while both entries are occupied
//  and stays high until the skid entry has moved to the output.
//  Reset clears the run count, alarm, previous angle and loads register
//  defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_alarm_qualifier (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Sample channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              mode_i,
  input  wire logic signed [8:0] angle_i,
  // Result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   alarm_now_o,
  output logic                   alarm_latched_o,
  output logic [7:0]             run_length_o,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Configuration registers
  logic signed [8:0] zero_angle_q;
  logic        [8:0] trip_angle_q;
  logic        [6:0] step_tolerance_q;
  logic        [7:0] run_needed_q;

  // Qualifier state
  logic [8:0] prev_q, prev_d;
  logic [7:0] run_q, run_d;
  logic       alarm_q, alarm_d;

  logic                cfg_write;
  tiltq_pkg::cfg_reg_e cfg_sel;
  logic                accept;
  logic                buf_full;

  logic [8:0]         sample_fold;
  logic [8:0]         zero_fold;
  logic               tilted;
  logic               step_break;
  logic [7:0]         run_inc;
  logic               run_hit;
  logic               now;
  tiltq_pkg::result_t result;
  tiltq_pkg::result_t out_data;

  // Decode configuration accesses
  assign pready    = 1'b1;
  assign cfg_sel   = tiltq_pkg::cfg_reg_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_angle_q     <= tiltq_pkg::ZeroAngleRst;
      trip_angle_q     <= tiltq_pkg::TripAngleRst;
      step_tolerance_q <= tiltq_pkg::StepToleranceRst;
      run_needed_q     <= tiltq_pkg::RunNeededRst;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        tiltq_pkg::RegZeroAngle:     zero_angle_q     <= pwdata[8:0];
        tiltq_pkg::RegTripAngle:     trip_angle_q     <= pwdata[8:0];
        tiltq_pkg::RegStepTolerance: step_tolerance_q <= pwdata[6:0];
        tiltq_pkg::RegRunNeeded:     run_needed_q     <= pwdata[7:0];
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (cfg_sel)
      tiltq_pkg::RegZeroAngle:     prdata = {{23{zero_angle_q[8]}}, zero_angle_q};
      tiltq_pkg::RegTripAngle:     prdata = {23'd0, trip_angle_q};
      tiltq_pkg::RegStepTolerance: prdata = {25'd0, step_tolerance_q};
      tiltq_pkg::RegRunNeeded:     prdata = {24'd0, run_needed_q};
    endcase
  end

  // Accept a sample whenever the output buffer has room
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !in_stall_o;

  // Fold and compare the sample
  assign sample_fold = tiltq_pkg::fold_angle(angle_i);
  assign zero_fold   = tiltq_pkg::fold_angle(zero_angle_q);
  assign tilted      = tiltq_pkg::abs_diff(sample_fold, zero_fold) > trip_angle_q;
  assign step_break  = tiltq_pkg::abs_diff(prev_q, sample_fold) > {2'b00, step_tolerance_q};
  assign run_inc     = (step_break ? 8'd0 : run_q) + 8'd1;
  assign run_hit     = run_inc >= run_needed_q;

  // Advance the run, raise or clear the alarm
  always_comb begin
    prev_d  = prev_q;
    run_d   = run_q;
    alarm_d = alarm_q;
    now     = 1'b0;
    priority if (mode_i) begin
      run_d   = 8'd0;
      alarm_d = 1'b0;
    end else if (tilted && run_hit) begin
      run_d   = 8'd0;
      alarm_d = 1'b1;
      now     = 1'b1;
    end else if (tilted) begin
      run_d  = run_inc;
      prev_d = sample_fold;
    end else begin
      run_d  = 8'd0;
      prev_d = sample_fold;
    end
  end

  // Hold qualifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 9'd0;
      run_q   <= 8'd0;
      alarm_q <= 1'b0;
    end else if (accept) begin
      prev_q  <= prev_d;
      run_q   <= run_d;
      alarm_q <= alarm_d;
    end
  end

  assign result.alarm_now     = now;
  assign result.alarm_latched = alarm_d;
  assign result.run_length    = run_d;

  // Register results towards the output channel
  tiltq_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign alarm_now_o     = out_data.alarm_now;
  assign alarm_latched_o = out_data.alarm_latched;
  assign run_length_o    = out_data.run_length;

`ifndef SYNTHESIS
  // A clear command always drops the alarm and the run
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i) |=> (!alarm_q && run_q == 8'd0))
    else $error("clear command left alarm or run set");

  // An alarm sample keeps the previous angle and zeroes the run
  a_alarm_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && now) |=> (alarm_q && run_q == 8'd0 && $stable(prev_q)))
    else $error("alarm sample disturbed state");

  // State only moves on an accepted transaction
  a_state_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(run_q) && $stable(alarm_q) && $stable(prev_q)))
    else $error("state changed without a transaction");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Tilt alarm qualifier testbench
// Drives samples and clear commands through the valid/stall input channel,
// predicts each result with an independent model of the run counter and the
// sticky alarm, and checks every result transaction field by field. Register
// settings change between phases over the APB port, from the extremes of
// each field to random mid-range values. Both sides idle in random bursts.
// The receiver holds off once for a long stretch, and the sender pauses once
// until every result has drained.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ModeSample = 1'b0;
  localparam logic ModeClear  = 1'b1;
  localparam int   FoldDeg    = 180;
  localparam int   LongHold   = 50;

  typedef struct {
    logic              clr;
    logic signed [8:0] angle;
  } sample_t;

  // DUT connections, all inputs at known values from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              mode_i      = ModeSample;
  logic signed [8:0] angle_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              alarm_now_o;
  logic              alarm_latched_o;
  logic [7:0]        run_length_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [3:0]        paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor copy of the registers and the qualifier state
  logic signed [8:0] cfg_zero  = tiltq_pkg::ZeroAngleRst;
  logic [8:0]        cfg_trip  = tiltq_pkg::TripAngleRst;
  logic [6:0]        cfg_tol   = tiltq_pkg::StepToleranceRst;
  logic [7:0]        cfg_run   = tiltq_pkg::RunNeededRst;
  logic [8:0]        prev_fold = '0;
  logic [7:0]        run_cnt   = '0;
  logic              alarm_q   = 1'b0;

  sample_t            sample_queue[$];
  tiltq_pkg::result_t expected_results[$];
  sample_t            next_sample;

  int  accepted_cnt  = 0;
  int  clears_sent   = 0;
  int  alarms_raised = 0;
  int  results_seen  = 0;
  int  mismatches    = 0;
  int  settings_used = 0;
  int  gap_left      = 0;
  int  stall_left    = 0;
  int  hold_left     = 0;
  bit  calm          = 1'b0;
  bit  sender_hold   = 1'b0;
  bit  stall_hold_req = 1'b0;

  tilt_alarm_qualifier u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .angle_i        (angle_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alarm_now_o    (alarm_now_o),
    .alarm_latched_o(alarm_latched_o),
    .run_length_o   (run_length_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Negative angles map to 180 - a, the rest stay as they are
  function automatic int fold_deg(input logic signed [8:0] a);
    return (a < 0) ? FoldDeg - int'(a) : int'(a);
  endfunction

  // Advance the qualifier state by one transaction and return its result
  function automatic tiltq_pkg::result_t qualify(input logic clr,
                                                 input logic signed [8:0] ang);
    tiltq_pkg::result_t r;
    int      p;
    int      dz;
    int      dp;
    bit      keep_prev;
    r.alarm_now = 1'b0;
    keep_prev   = 1'b0;
    if (clr == ModeClear) begin
      run_cnt = '0;
      alarm_q = 1'b0;
    end else begin
      p  = fold_deg(ang);
      dz = p - fold_deg(cfg_zero);
      if (dz < 0) dz = -dz;
      if (dz > int'(cfg_trip)) begin
        dp = int'(prev_fold) - p;
        if (dp < 0) dp = -dp;
        // A jump beyond the tolerance restarts the run
        if (dp > int'(cfg_tol)) run_cnt = '0;
        run_cnt = run_cnt + 8'd1;
        if (run_cnt >= cfg_run) begin
          run_cnt     = '0;
          alarm_q     = 1'b1;
          r.alarm_now = 1'b1;
          keep_prev   = 1'b1;
          alarms_raised++;
        end
      end else begin
        run_cnt = '0;
      end
      if (!keep_prev) prev_fold = p[8:0];
    end
    r.alarm_latched = alarm_q;
    r.run_length    = run_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    mismatches++;
    $display("%0t ns: %s expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  // Sender: predict each accepted transaction, then offer the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(qualify(mode_i, angle_i));
        accepted_cnt++;
        if (mode_i == ModeClear) clears_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() > 0 && !sender_hold) begin
          next_sample = sample_queue.pop_front();
          in_valid_i <= 1'b1;
          mode_i     <= next_sample.clr;
          angle_i    <= next_sample.angle;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction, then decide the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected (now %0b latched %0b run %0d)",
                   $time, alarm_now_o, alarm_latched_o, run_length_o);
        end else begin
          tiltq_pkg::result_t want;
          want = expected_results.pop_front();
          if (alarm_now_o !== want.alarm_now)
            report_mismatch("alarm_now", want.alarm_now, alarm_now_o);
          if (alarm_latched_o !== want.alarm_latched)
            report_mismatch("alarm_latched", want.alarm_latched, alarm_latched_o);
          if (run_length_o !== want.run_length)
            report_mismatch("run_length", want.run_length, run_length_o);
        end
      end
      if (stall_hold_req) begin
        hold_left      = LongHold;
        stall_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_sample(input logic clr, input logic signed [8:0] a);
    sample_t s;
    s.clr   = clr;
    s.angle = a;
    sample_queue.push_back(s);
  endtask

  // APB write: setup cycle, then access cycle; register lands at its end
  task automatic write_reg(input tiltq_pkg::cfg_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tiltq_pkg::RegZeroAngle:     cfg_zero = value[8:0];
      tiltq_pkg::RegTripAngle:     cfg_trip = value[8:0];
      tiltq_pkg::RegStepTolerance: cfg_tol  = value[6:0];
      tiltq_pkg::RegRunNeeded:     cfg_run  = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int zero, input int trip, input int tol, input int run);
    write_reg(tiltq_pkg::RegZeroAngle, 32'(zero));
    write_reg(tiltq_pkg::RegTripAngle, 32'(trip));
    write_reg(tiltq_pkg::RegStepTolerance, 32'(tol));
    write_reg(tiltq_pkg::RegRunNeeded, 32'(run));
    settings_used++;
  endtask

  // Hold until every queued sample is accepted and every result has arrived
  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Mostly walks near the tolerance around tilted points, with clears,
  // jumps and fully random angles mixed in
  task automatic fill_random(input int n);
    int cur;
    int off;
    int roll;
    cur = int'(cfg_zero);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        push_sample(ModeClear, 9'($urandom));
      end else begin
        if (roll < 18) begin
          cur = int'($urandom_range(0, 511)) - 256;
        end else if (roll < 32) begin
          off = int'(cfg_trip) + int'($urandom_range(1, 20));
          cur = $urandom_range(0, 1) ? int'(cfg_zero) + off : int'(cfg_zero) - off;
        end else begin
          cur = cur + int'($urandom_range(0, 2 * int'(cfg_tol) + 2)) - (int'(cfg_tol) + 1);
        end
        if (cur > 255) cur = 255;
        if (cur < -256) cur = -256;
        push_sample(ModeSample, cur[8:0]);
      end
    end
  endtask

  // Stimulus sequence and end of run
  initial begin
    int base;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset settings: extremes, alarm, step break
    push_sample(ModeSample, 9'sd0);
    push_sample(ModeSample, 9'sd255);
    push_sample(ModeSample, -9'sd256);
    push_sample(ModeClear, -9'sd1);
    for (int a = 20; a <= 25; a++) push_sample(ModeSample, a[8:0]);
    push_sample(ModeSample, 9'sd26);
    push_sample(ModeSample, 9'sd40);
    push_sample(ModeSample, -9'sd180);
    push_sample(ModeSample, 9'sd180);
    push_sample(ModeSample, -9'sd1);
    push_sample(ModeSample, 9'sd3);
    push_sample(ModeSample, 9'sd7);
    push_sample(ModeClear, 9'sd255);
    push_sample(ModeSample, -9'sd20);
    wait_drained();

    // Low extremes: zero run needed, zero trip and tolerance
    apply_settings(-180, 0, 0, 0);
    fill_random(60);
    wait_drained();

    // High extremes of trip, tolerance and run needed; lowest zero angle
    apply_settings(-256, 511, 127, 255);
    fill_random(40);
    wait_drained();

    apply_settings(255, 360, 0, 1);
    fill_random(50);
    wait_drained();

    // Random mid-range settings; the last phase runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      apply_settings(int'($urandom_range(0, 360)) - 180, $urandom_range(0, 30),
                     $urandom_range(0, 15), $urandom_range(0, 10));
      calm = (ph == 5);
      base = accepted_cnt;
      fill_random(80);
      if (ph == 0) begin
        while (accepted_cnt < base + 30) @(posedge clk_i);
        @(negedge clk_i) stall_hold_req = 1'b1;
      end
      if (ph == 1) begin
        while (accepted_cnt < base + 30) @(posedge clk_i);
        @(negedge clk_i) sender_hold = 1'b1;
        while (in_valid_i || expected_results.size() != 0) @(posedge clk_i);
        @(negedge clk_i) sender_hold = 1'b0;
      end
      wait_drained();
    end

    // Trailing window to catch any stray result
    repeat (10) @(posedge clk_i);
    $display("Checked %0d results from %0d transactions (%0d clears, %0d alarms raised)",
             results_seen, accepted_cnt, clears_sent, alarms_raised);
    $display("over %0d register settings; %0d mismatches", settings_used + 1, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tilt_alarm_qualifier: match");
    end else begin
      $display("tilt_alarm_qualifier: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tilt_alarm_qualifier: mismatch");
    $finish;
  end

endmodule
